// ----- design/tcw_pkg.sv -----
// tcw_pkg: shared types and constants of the text console writer
// no dependencies; used by tcw_front, tcw_back and text_console_writer_core

package tcw_pkg;

  // character codes with a meaning of their own
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_LF    = 8'h0a;
  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // configuration register indexes and reset values
  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;
  localparam logic [3:0] FG_RESET = 4'hF;
  localparam logic [3:0] BG_RESET = 4'h0;

  // request classes handed from the front to the back
  typedef enum logic [2:0] {
    K_CHAR,
    K_TAB,
    K_LF,
    K_NOP,
    K_READ
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  chr;
    logic        advance;
    logic [6:0]  read_col;
    logic [4:0]  read_row;
  } cmd_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } res_t;

endpackage

// ----- design/tcw_ram.sv -----
// tcw_ram: generic single-write, single-read memory with registered read data
// no dependencies

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tcw_fifo.sv -----
// tcw_fifo: two-entry register queue used between the block's parts
// no dependencies

module tcw_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic [1:0]       count_q, count_d;
  logic             wr_q, rd_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- design/tcw_front.sv -----
// tcw_front: accepts requests, classifies them and queues them for the back
// depends on tcw_pkg and tcw_fifo

module tcw_front #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic          hold_i,
  input  logic          func_i,
  input  logic [7:0]    chr_i,
  input  logic          advance_i,
  input  logic [6:0]    read_col_i,
  input  logic [4:0]    read_row_i,
  output tcw_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i
);

  tcw_pkg::cmd_t               cmd_in;
  logic [$bits(tcw_pkg::cmd_t)-1:0] cmd_vec;
  logic                        q_full, q_empty, in_range;

  assign in_range = (32'(read_col_i) < COLS) && (32'(read_row_i) < ROWS);

  always_comb begin
    cmd_in.chr      = chr_i;
    cmd_in.advance  = advance_i;
    cmd_in.read_col = read_col_i;
    cmd_in.read_row = read_row_i;
    if (func_i) begin
      // out-of-range reads give a zero cell and change nothing
      cmd_in.kind = in_range ? tcw_pkg::K_READ : tcw_pkg::K_NOP;
    end else begin
      unique case (chr_i)
        tcw_pkg::CHR_TAB: cmd_in.kind = tcw_pkg::K_TAB;
        tcw_pkg::CHR_LF:  cmd_in.kind = tcw_pkg::K_LF;
        tcw_pkg::CHR_CR:  cmd_in.kind = tcw_pkg::K_NOP;
        default:          cmd_in.kind = tcw_pkg::K_CHAR;
      endcase
    end
  end

  assign full_o = q_full || hold_i;

  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::cmd_t))
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i && !hold_i),
    .data_i (cmd_in),
    .full_o (q_full),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_vec),
    .empty_o(q_empty)
  );

  assign cmd_o       = tcw_pkg::cmd_t'(cmd_vec);
  assign cmd_valid_o = !q_empty;

endmodule

// ----- design/tcw_back.sv -----
// tcw_back: executes queued requests on the screen store and the cursor
// depends on tcw_pkg and tcw_ram

module tcw_back #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcw_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  logic [7:0]    attr_i,
  output tcw_pkg::res_t res_o,
  output logic          res_push_o,
  input  logic          res_full_i,
  output logic          init_busy_o
);

  localparam int unsigned DEPTH = ROWS * COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_COPY = AW'((ROWS - 1) * COLS - 1);
  localparam logic [AW-1:0] BOT_ROW   = AW'((ROWS - 1) * COLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_TAB,
    S_SC_RD,
    S_SC_WR,
    S_ROWCLR,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_TAB,
    RET_DONE
  } ret_e;

  state_e         state_q, state_d;
  ret_e           ret_q, ret_d;
  logic [CW-1:0]  x_q, x_d;
  logic [RW-1:0]  y_q, y_d;
  logic [AW-1:0]  sc_addr_q, sc_addr_d;
  logic [15:0]    cell_q, cell_d;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [15:0]    ram_wdata, ram_rdata;

  logic [AW-1:0]  cur_addr;
  logic [CW:0]    x_inc;
  logic           wrap, last_row;

  assign cur_addr = AW'(32'(y_q) * COLS + 32'(x_q));
  assign x_inc    = (CW + 1)'(x_q) + (CW + 1)'(1);
  assign wrap     = (32'(x_inc) == COLS);
  assign last_row = (32'(y_q) == ROWS - 1);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    x_d       = x_q;
    y_d       = y_q;
    sc_addr_d = sc_addr_q;
    cell_d    = cell_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cur_addr;
    ram_raddr = AW'(32'(sc_addr_q) + COLS);
    ram_wdata = {tcw_pkg::CHR_SPACE, attr_i};
    cmd_pop_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cell_d    = 16'h0000;
          unique case (cmd_i.kind)
            tcw_pkg::K_READ: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(32'(cmd_i.read_row) * COLS + 32'(cmd_i.read_col));
              state_d   = S_RDWAIT;
            end
            tcw_pkg::K_TAB: begin
              state_d = S_TAB;
            end
            tcw_pkg::K_LF: begin
              x_d = '0;
              if (last_row) begin
                sc_addr_d = '0;
                ret_d     = RET_DONE;
                state_d   = S_SC_RD;
              end else begin
                y_d     = y_q + RW'(1);
                state_d = S_DONE;
              end
            end
            tcw_pkg::K_CHAR: begin
              ram_we    = 1'b1;
              ram_wdata = {cmd_i.chr, attr_i};
              state_d   = S_DONE;
              if (cmd_i.advance) begin
                if (wrap) begin
                  x_d = '0;
                  if (last_row) begin
                    sc_addr_d = '0;
                    ret_d     = RET_DONE;
                    state_d   = S_SC_RD;
                  end else begin
                    y_d = y_q + RW'(1);
                  end
                end else begin
                  x_d = CW'(x_inc);
                end
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        cell_d  = ram_rdata;
        state_d = S_DONE;
      end
      S_TAB: begin
        // one space a cycle (paused while a bottom-row wrap scrolls) until the column lands one past a multiple of four
        ram_we = 1'b1;
        if (wrap) begin
          x_d = '0;
          if (last_row) begin
            sc_addr_d = '0;
            ret_d     = RET_TAB;
            state_d   = S_SC_RD;
          end else begin
            y_d = y_q + RW'(1);
          end
        end else begin
          x_d = CW'(x_inc);
          if (x_inc[1:0] == 2'b01) begin
            state_d = S_DONE;
          end
        end
      end
      S_SC_RD: begin
        ram_re  = 1'b1;
        state_d = S_SC_WR;
      end
      S_SC_WR: begin
        ram_we    = 1'b1;
        ram_waddr = sc_addr_q;
        ram_wdata = ram_rdata;
        if (sc_addr_q == LAST_COPY) begin
          sc_addr_d = BOT_ROW;
          state_d   = S_ROWCLR;
        end else begin
          sc_addr_d = sc_addr_q + AW'(1);
          state_d   = S_SC_RD;
        end
      end
      S_ROWCLR: begin
        ram_we    = 1'b1;
        ram_waddr = sc_addr_q;
        ram_wdata = 16'h0000;
        if (sc_addr_q == LAST_CELL) begin
          unique case (ret_q)
            RET_TAB:  state_d = S_TAB;
            RET_DONE: state_d = S_DONE;
            default:  state_d = S_IDLE;
          endcase
        end else begin
          sc_addr_d = sc_addr_q + AW'(1);
        end
      end
      S_DONE: begin
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // reset starts a clearing pass over the whole store
      state_q   <= S_ROWCLR;
      ret_q     <= RET_IDLE;
      sc_addr_q <= '0;
      x_q       <= '0;
      y_q       <= '0;
      cell_q    <= 16'h0000;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      sc_addr_q <= sc_addr_d;
      x_q       <= x_d;
      y_q       <= y_d;
      cell_q    <= cell_d;
    end
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign res_o.cell_char  = cell_q[15:8];
  assign res_o.cell_attr  = cell_q[7:0];
  assign res_o.cursor_col = 7'(x_q);
  assign res_o.cursor_row = 5'(y_q);
  assign res_push_o       = (state_q == S_DONE) && !res_full_i;
  assign init_busy_o      = (state_q == S_ROWCLR) && (ret_q == RET_IDLE);

endmodule

// ----- design/text_console_writer_core.sv -----
// text_console_writer_core: top level of the text-mode console engine
// depends on tcw_pkg, tcw_front, tcw_back, tcw_fifo and tcw_ram

// text-mode console with a ROWS x COLS store of 16-bit cells (character in
// the high byte, attribute bg<<4|fg in the low byte) and a cursor. requests
// enter through a queue port (push/full) and every request yields exactly one
// result on a queue port (empty/pop) carrying the read cell and the cursor
// after the request. a front part classifies requests into a two-entry queue,
// a back part runs a small sequencer on the single-port-pair screen memory,
// and a two-entry result queue decouples the consumer. the memory takes one
// write and one registered read per cycle. carriage return, line feed without
// scroll and plain characters go from idle straight to the result state, reads
// pass a read-wait state, and tabs write one space per cycle unless a scroll
// comes between. a new line or a character or tab wrap on the bottom row
// scrolls: each of the (ROWS-1)*COLS cells is moved by a read state and a
// write state, then the bottom row is cleared one cell a cycle. after reset
// a clearing pass zeroes the store, and full stays high until it ends. the user
// must write colors via cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; the block does not enforce it.

module text_console_writer_core #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request side
  input  logic       push,
  output logic       full,
  input  logic       func_i,
  input  logic [7:0] chr_i,
  input  logic       advance_i,
  input  logic [6:0] read_col_i,
  input  logic [4:0] read_row_i,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attr_o,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_wdata_i
);

  logic [3:0]    fg_q, bg_q;
  tcw_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;
  tcw_pkg::res_t res_in, res_out;
  logic [$bits(tcw_pkg::res_t)-1:0] res_vec;
  logic          res_push, res_full, init_busy;

  // color registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= tcw_pkg::FG_RESET;
      bg_q <= tcw_pkg::BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcw_pkg::REG_FG: fg_q <= cfg_wdata_i;
        tcw_pkg::REG_BG: bg_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: accept and classify requests, held off during the clearing pass
  tcw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .hold_i     (init_busy),
    .func_i     (func_i),
    .chr_i      (chr_i),
    .advance_i  (advance_i),
    .read_col_i (read_col_i),
    .read_row_i (read_row_i),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  // back: screen store, cursor and scroll sequencer
  tcw_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .attr_i     ({bg_q, fg_q}),
    .res_o      (res_in),
    .res_push_o (res_push),
    .res_full_i (res_full),
    .init_busy_o(init_busy)
  );

  // result queue
  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::res_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_vec),
    .empty_o(empty)
  );

  assign res_out      = tcw_pkg::res_t'(res_vec);
  assign cell_char_o  = res_out.cell_char;
  assign cell_attr_o  = res_out.cell_attr;
  assign cursor_col_o = res_out.cursor_col;
  assign cursor_row_o = res_out.cursor_row;

`ifndef SYNTHESIS
  // the back never hands a result to a full result queue
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // no request is taken from the queue during the clearing pass
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> !cmd_pop)
    else $error("request taken during clearing pass");

  // a waiting result carries a cursor inside the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(cursor_col_o) < COLS) && (32'(cursor_row_o) < ROWS))
    else $error("cursor out of range");

  // the request side stays closed while the clearing pass runs
  a_full_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> full)
    else $error("request side open during clearing pass");
`endif

endmodule
